### hw/rtl/cpr_pkg.sv
package cpr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 32;
	localparam int unsigned CMD_DEPTH = 2;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

	localparam logic [5:0] EXPECTED_LENGTH_RST = 6'd0;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10000;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd1;
	localparam logic [1:0] STATUS_FAIL = 2'd2;

	localparam logic [1:0] LINE_OK = 2'd0;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_LENGTH = 3'd4;
	localparam logic [2:0] ERR_CHECKSUM = 3'd5;

	localparam logic [7:0] REPLY_OK = 8'h00;
	localparam logic [7:0] REPLY_FAIL = 8'h01;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic [1:0] line_error;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        last;
		logic [1:0]  packet_status;
		logic [2:0]  error_code;
		logic [5:0]  payload_length;
		logic [15:0] good_packets;
		logic [15:0] line_errors;
		logic [15:0] timeouts;
		logic [15:0] length_errors;
		logic [15:0] checksum_errors;
	} result_t;

	typedef struct packed {
		logic [15:0] good;
		logic [15:0] line;
		logic [15:0] timeout;
		logic [15:0] length;
		logic [15:0] checksum;
	} counters_t;

	typedef struct packed {
		logic        fail;
		logic [2:0]  code;
		logic [5:0]  len;
		logic [7:0]  sum;
		counters_t   cnt;
	} cmd_t;

	typedef struct packed {
		logic       en;
		logic [5:0] addr;
		logic [7:0] data;
	} mem_wr_t;

endpackage

### hw/rtl/cpr_front.sv
module cpr_front #(
	parameter int unsigned MAX_PAYLOAD = cpr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  cpr_pkg::item_t                      item,
	input  logic                                cfg_wr_en,
	input  logic [cpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cpr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                cmd_full,
	input  logic                                cmd_empty,
	input  logic                                back_busy,
	output logic                                cmd_push,
	output cpr_pkg::cmd_t                       cmd,
	output cpr_pkg::mem_wr_t                    mem_wr
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	phase_t             phase_q;
	logic [5:0]         byte_index_q;
	logic [7:0]         running_sum_q;
	logic [15:0]        wait_count_q;
	logic [5:0]         expected_length_q;
	logic [15:0]        timeout_ticks_q;
	cpr_pkg::counters_t cnt_q;
	cpr_pkg::counters_t cnt_d;

	logic        accept;
	logic        is_byte;
	logic        line_ok;
	logic        wr_hazard;
	logic        len_bad;
	logic        timeout_hit;
	logic [5:0]  idx_inc;
	logic [7:0]  sum_add;
	logic [15:0] wait_inc;
	logic        fail_c;
	logic [2:0]  code_c;

	assign is_byte = (item.op == cpr_pkg::OP_BYTE);
	assign line_ok = (item.line_error == cpr_pkg::LINE_OK);
	assign idx_inc = byte_index_q + 6'd1;
	assign sum_add = running_sum_q + item.rx_byte;
	assign wait_inc = wait_count_q + 16'd1;

	// the store may not be overwritten while an earlier packet is still queued or delivered
	assign wr_hazard = is_byte && line_ok && (phase_q == PH_PAYLOAD) && (!cmd_empty || back_busy);
	assign item_stall = cmd_full || wr_hazard;
	assign accept = item_valid && !item_stall;

	assign len_bad = (item.rx_byte != {2'b00, expected_length_q})
		|| (item.rx_byte > 8'(MAX_PAYLOAD));
	assign timeout_hit = accept && !is_byte && (phase_q != PH_IDLE)
		&& (wait_inc >= timeout_ticks_q);

	always_comb begin
		cnt_d = cnt_q;
		cmd_push = 1'b0;
		fail_c = 1'b1;
		code_c = cpr_pkg::ERR_NONE;
		if (timeout_hit) begin
			cnt_d.timeout = cnt_q.timeout + 16'd1;
		end
		if (accept && is_byte) begin
			if (!line_ok) begin
				cnt_d.line = cnt_q.line + 16'd1;
				cmd_push = 1'b1;
				code_c = {1'b0, item.line_error};
			end else begin
				case (phase_q)
					PH_IDLE: begin
						if (len_bad) begin
							cnt_d.length = cnt_q.length + 16'd1;
							cmd_push = 1'b1;
							code_c = cpr_pkg::ERR_LENGTH;
						end
					end
					PH_CHECK: begin
						cmd_push = 1'b1;
						if (running_sum_q != item.rx_byte) begin
							cnt_d.checksum = cnt_q.checksum + 16'd1;
							code_c = cpr_pkg::ERR_CHECKSUM;
						end else begin
							cnt_d.good = cnt_q.good + 16'd1;
							fail_c = 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign cmd.fail = fail_c;
	assign cmd.code = code_c;
	assign cmd.len = fail_c ? 6'd0 : byte_index_q;
	assign cmd.sum = running_sum_q;
	assign cmd.cnt = cnt_d;

	assign mem_wr.en = accept && is_byte && line_ok && (phase_q == PH_PAYLOAD);
	assign mem_wr.addr = byte_index_q;
	assign mem_wr.data = item.rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			byte_index_q <= '0;
			running_sum_q <= '0;
			wait_count_q <= '0;
			expected_length_q <= cpr_pkg::EXPECTED_LENGTH_RST;
			timeout_ticks_q <= cpr_pkg::TIMEOUT_TICKS_RST;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					cpr_pkg::REG_EXPECTED_LENGTH: expected_length_q <= cfg_data[5:0];
					cpr_pkg::REG_TIMEOUT_TICKS:   timeout_ticks_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (!is_byte) begin
					if (phase_q != PH_IDLE) begin
						if (timeout_hit) begin
							phase_q <= PH_IDLE;
							byte_index_q <= '0;
							running_sum_q <= '0;
							wait_count_q <= '0;
						end else begin
							wait_count_q <= wait_inc;
						end
					end
				end else begin
					wait_count_q <= '0;
					if (cmd_push) begin
						phase_q <= PH_IDLE;
						byte_index_q <= '0;
						running_sum_q <= '0;
					end else begin
						case (phase_q)
							PH_IDLE: begin
								running_sum_q <= item.rx_byte;
								byte_index_q <= '0;
								phase_q <= (item.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
							end
							PH_PAYLOAD: begin
								running_sum_q <= sum_add;
								byte_index_q <= idx_inc;
								if ((idx_inc >= expected_length_q) || (idx_inc >= 6'(MAX_PAYLOAD))) begin
									phase_q <= PH_CHECK;
								end
							end
							default: ;
						endcase
					end
				end
			end
		end
	end

endmodule

### hw/rtl/cpr_cmd_fifo.sv
module cpr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cpr_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output cpr_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          empty
);

	localparam int unsigned DEPTH = cpr_pkg::CMD_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cpr_pkg::cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/cpr_back.sv
module cpr_back #(
	parameter int unsigned MAX_PAYLOAD = cpr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  cpr_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	output logic              busy,
	input  cpr_pkg::mem_wr_t  mem_wr,
	output logic              result_valid,
	input  logic              result_stall,
	output cpr_pkg::result_t  result
);

	localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REPLY0,
		S_REPLY1,
		S_FETCH,
		S_PAYLOAD
	} state_t;

	state_t        state_q;
	cpr_pkg::cmd_t cur_q;
	logic [5:0]    idx_q;
	logic [7:0]    rd_data_q;
	logic [7:0]    store_mem [MAX_PAYLOAD];

	logic             load_ok;
	logic             emit;
	logic [5:0]       idx_inc;
	cpr_pkg::result_t base;
	cpr_pkg::result_t load_val;

	assign load_ok = !result_valid || !result_stall;
	assign emit = load_ok && (state_q inside {S_REPLY0, S_REPLY1, S_PAYLOAD});
	assign idx_inc = idx_q + 6'd1;
	assign busy = (state_q != S_IDLE);
	assign cmd_pop = (state_q == S_IDLE) && !cmd_empty;

	always_comb begin
		base.kind = cpr_pkg::KIND_REPLY;
		base.data = cur_q.fail ? cpr_pkg::REPLY_FAIL : cpr_pkg::REPLY_OK;
		base.last = 1'b0;
		base.packet_status = cur_q.fail ? cpr_pkg::STATUS_FAIL : cpr_pkg::STATUS_OK;
		base.error_code = cur_q.code;
		base.payload_length = cur_q.len;
		base.good_packets = cur_q.cnt.good;
		base.line_errors = cur_q.cnt.line;
		base.timeouts = cur_q.cnt.timeout;
		base.length_errors = cur_q.cnt.length;
		base.checksum_errors = cur_q.cnt.checksum;
	end

	always_comb begin
		load_val = base;
		case (state_q)
			S_REPLY1: begin
				load_val.data = cur_q.fail ? {5'd0, cur_q.code} : cur_q.sum;
				load_val.last = cur_q.fail || (cur_q.len == 6'd0);
			end
			S_PAYLOAD: begin
				load_val.kind = cpr_pkg::KIND_PAYLOAD;
				load_val.data = rd_data_q;
				load_val.last = (idx_inc == cur_q.len);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			store_mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
		end
		rd_data_q <= store_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0;
			idx_q <= '0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			if (emit) begin
				result <= load_val;
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						cur_q <= cmd;
						idx_q <= '0;
						state_q <= S_REPLY0;
					end
				end
				S_REPLY0: begin
					if (load_ok) begin
						state_q <= S_REPLY1;
					end
				end
				S_REPLY1: begin
					if (load_ok) begin
						state_q <= load_val.last ? S_IDLE : S_FETCH;
					end
				end
				// read data for idx_q is registered and lands in the cycle after the address settles
				S_FETCH: state_q <= S_PAYLOAD;
				S_PAYLOAD: begin
					if (load_ok) begin
						idx_q <= idx_inc;
						state_q <= load_val.last ? S_IDLE : S_FETCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/checksummed_packet_receiver_unit.sv
// a packet's first reply passes the command queue, cur_q and the result register
// throughput: one byte or tick a cycle; payload bytes wait while an earlier packet is
// still queued or delivered, and input waits while the two-entry command queue is full
// output: reply bytes one a cycle if not stalled; payload via registered store reads
// reset: asynchronous, clears phase, counters, queue and registers to their defaults;
// the payload store and its read register are not cleared
module checksummed_packet_receiver_unit #(
	parameter int unsigned MAX_PAYLOAD = cpr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  cpr_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output cpr_pkg::result_t                result,
	input  logic                            cfg_wr_en,
	input  logic [cpr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic             cmd_push;
	logic             cmd_pop;
	logic             cmd_full;
	logic             cmd_empty;
	logic             back_busy;
	cpr_pkg::cmd_t    cmd_in;
	cpr_pkg::cmd_t    cmd_head;
	cpr_pkg::mem_wr_t mem_wr;

	cpr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_full   (cmd_full),
		.cmd_empty  (cmd_empty),
		.back_busy  (back_busy),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.mem_wr     (mem_wr)
	);

	cpr_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (cmd_in),
		.pop    (cmd_pop),
		.rd_cmd (cmd_head),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	cpr_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (cmd_empty),
		.cmd          (cmd_head),
		.cmd_pop      (cmd_pop),
		.busy         (back_busy),
		.mem_wr       (mem_wr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_push && cmd_full))
		else $error("command pushed into a full queue");

	a_store_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> (!back_busy && cmd_empty))
		else $error("payload store written while a delivery is pending");

	a_tick_no_request: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.op == cpr_pkg::OP_TICK) |-> !cmd_push)
		else $error("tick produced a reply request");

	a_pop_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> back_busy)
		else $error("back end idle after taking a request");
`endif

endmodule
